// ===== rtl/rmm_pkg.sv =====
// Package with the shared constants, codes and control types of the running statistics block.
package rmm_pkg;

  // Sample format and the Q1.31 mean accumulator.
  localparam int unsigned SampleBits = 16;
  localparam int unsigned MeanBits   = 32;
  localparam int unsigned MeanShift  = MeanBits - SampleBits;

  // Peak-to-peak window.
  localparam int unsigned WinLen   = 200;
  localparam int unsigned FillBits = $clog2(WinLen + 1);

  // Sequential divider: one quotient bit per step.
  localparam int unsigned DivSteps   = MeanBits;
  localparam int unsigned DivCntBits = $clog2(DivSteps);

  // Configuration port.
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgMaxLimit = 2'd0,
    CfgMinSeed  = 2'd1,
    CfgMeanSeed = 2'd2
  } cfg_idx_e;

  // Register reset values: 1.201 V, 1.2 V and 0.5 V in Q1.15.
  localparam logic [SampleBits-1:0] MaxLimitRst = 16'd39354;
  localparam logic [SampleBits-1:0] MinSeedRst  = 16'd39322;
  localparam logic [SampleBits-1:0] MeanSeedRst = 16'd16384;

  // Item codes carried in the func field.
  localparam logic FuncSample = 1'b0;
  localparam logic FuncClear  = 1'b1;

  typedef logic [SampleBits-1:0] sample_t;

  typedef enum logic [2:0] {
    StIdle,
    StApply,
    StDivide,
    StCommit,
    StResult
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic apply_clear;
    logic apply_sample;
    logic mean_commit;
    logic push_result;
  } rmm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic func;
    logic div_done;
    logic out_free;
  } rmm_sts_t;

endpackage

// ===== rtl/rmm_in_if.sv =====
// Input channel interface: valid/ready handshake with the func and sample payload.
interface rmm_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  rmm_pkg::sample_t  sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink (input valid, input func, input sample, output ready);
endinterface

// ===== rtl/rmm_out_if.sv =====
// Output channel interface: valid/ready handshake with the four statistics fields.
interface rmm_out_if;
  logic              valid;
  logic              ready;
  rmm_pkg::sample_t  min_value;
  rmm_pkg::sample_t  max_value;
  rmm_pkg::sample_t  mean_value;
  rmm_pkg::sample_t  peak_to_peak;

  modport source (output valid, output min_value, output max_value, output mean_value,
                  output peak_to_peak, input ready);
  modport sink (input valid, input min_value, input max_value, input mean_value,
                input peak_to_peak, output ready);
endinterface

// ===== rtl/rmm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
module rmm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rmm_pkg::MeanBits-1:0] dividend_i,
  input  logic [rmm_pkg::MeanBits:0]   divisor_i,
  output logic                         done_o,
  output logic [rmm_pkg::MeanBits-1:0] quot_o
);

  localparam int unsigned W = rmm_pkg::MeanBits;

  logic                                busy_q;
  logic                                done_q;
  logic [rmm_pkg::DivCntBits-1:0]      cnt_q;
  logic [W:0]                          rem_q, rem_d;
  logic [W-1:0]                        quo_q, quo_d;
  logic [W:0]                          den_q;
  logic [W+1:0]                        shifted;
  logic [W+1:0]                        trial;
  logic                                ge;

  // The partial remainder stays below the divisor, so it fits W+1 bits.
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    ge      = (shifted >= {1'b0, den_q});
    trial   = shifted - {1'b0, den_q};
    rem_d   = ge ? trial[W:0] : shifted[W:0];
    quo_d   = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == rmm_pkg::DivCntBits'(rmm_pkg::DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/rmm_dp.sv =====
// Datapath: configuration registers, statistics state, mean divider and output register.
module rmm_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmm_pkg::rmm_cmd_t                 cmd_i,
  output rmm_pkg::rmm_sts_t                 sts_o,
  input  logic                              cfg_we_i,
  input  logic [rmm_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [rmm_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  input  logic                              in_func_i,
  input  rmm_pkg::sample_t                  in_sample_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output rmm_pkg::sample_t                  out_min_o,
  output rmm_pkg::sample_t                  out_max_o,
  output rmm_pkg::sample_t                  out_mean_o,
  output rmm_pkg::sample_t                  out_p2p_o
);

  localparam int unsigned MW = rmm_pkg::MeanBits;
  localparam int unsigned SW = rmm_pkg::SampleBits;

  // Configuration.
  rmm_pkg::sample_t limit_q, min_seed_q, mean_seed_q;

  // Captured item.
  logic             func_q;
  rmm_pkg::sample_t smp_q;

  // Statistics state.
  rmm_pkg::sample_t               min_q, min_d;
  rmm_pkg::sample_t               max_q, max_d;
  logic [MW-1:0]                  mean_q, mean_d;
  logic [MW-1:0]                  count_q, count_d;
  logic [rmm_pkg::FillBits-1:0]   fill_q, fill_d;
  rmm_pkg::sample_t               win_hi_q, win_hi_d;
  rmm_pkg::sample_t               win_lo_q, win_lo_d;
  rmm_pkg::sample_t               p2p_q, p2p_d;
  logic                           neg_q;

  // Mean update operands.
  logic [MW:0]   diff;
  logic [MW-1:0] diff_mag;
  logic [MW:0]   divisor;
  logic [MW-1:0] quot;
  logic          div_done;
  logic          out_valid_q;
  rmm_pkg::sample_t out_min_q, out_max_q, out_mean_q, out_p2p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= rmm_pkg::MaxLimitRst;
      min_seed_q  <= rmm_pkg::MinSeedRst;
      mean_seed_q <= rmm_pkg::MeanSeedRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rmm_pkg::CfgMaxLimit: limit_q     <= cfg_wdata_i;
        rmm_pkg::CfgMinSeed:  min_seed_q  <= cfg_wdata_i;
        rmm_pkg::CfgMeanSeed: mean_seed_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= in_func_i;
      smp_q  <= in_sample_i;
    end
  end

  // Signed difference between the sample and the mean; the divisor is the new count plus one.
  always_comb begin
    diff     = {1'b0, smp_q, {rmm_pkg::MeanShift{1'b0}}} - {1'b0, mean_q};
    diff_mag = diff[MW] ? MW'(-diff) : diff[MW-1:0];
  end

  always_comb begin
    min_d    = min_q;
    max_d    = max_q;
    mean_d   = mean_q;
    count_d  = count_q;
    fill_d   = fill_q;
    win_hi_d = win_hi_q;
    win_lo_d = win_lo_q;
    p2p_d    = p2p_q;
    if (cmd_i.apply_clear) begin
      min_d   = min_seed_q;
      max_d   = '0;
      mean_d  = {mean_seed_q, {rmm_pkg::MeanShift{1'b0}}};
      p2p_d   = '0;
      count_d = '0;
    end else if (cmd_i.apply_sample) begin
      if (smp_q > max_q && smp_q < limit_q) max_d = smp_q;
      if (smp_q < min_q) min_d = smp_q;
      if (count_q != '1) count_d = count_q + 1'b1;
      if (fill_q < rmm_pkg::FillBits'(rmm_pkg::WinLen)) begin
        if (smp_q > win_hi_q) win_hi_d = smp_q;
        if (smp_q < win_lo_q) win_lo_d = smp_q;
        fill_d = fill_q + 1'b1;
      end else begin
        p2p_d    = (win_hi_q >= win_lo_q) ? SW'(win_hi_q - win_lo_q) : '0;
        fill_d   = '0;
        win_hi_d = '0;
        win_lo_d = min_seed_q;
      end
    end else if (cmd_i.mean_commit) begin
      mean_d = neg_q ? mean_q - quot : mean_q + quot;
    end
  end

  assign divisor = {1'b0, count_d} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= rmm_pkg::MinSeedRst;
      max_q    <= '0;
      mean_q   <= {rmm_pkg::MeanSeedRst, {rmm_pkg::MeanShift{1'b0}}};
      count_q  <= '0;
      fill_q   <= '0;
      win_hi_q <= '0;
      win_lo_q <= rmm_pkg::MinSeedRst;
      p2p_q    <= '0;
    end else begin
      min_q    <= min_d;
      max_q    <= max_d;
      mean_q   <= mean_d;
      count_q  <= count_d;
      fill_q   <= fill_d;
      win_hi_q <= win_hi_d;
      win_lo_q <= win_lo_d;
      p2p_q    <= p2p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply_sample) neg_q <= diff[MW];
  end

  rmm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.apply_sample),
    .dividend_i (diff_mag),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Output register: the result waits here while the next word is taken in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_result) begin
      out_min_q  <= min_q;
      out_max_q  <= max_q;
      out_mean_q <= mean_q[MW-1:rmm_pkg::MeanShift];
      out_p2p_q  <= p2p_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_min_o   = out_min_q;
  assign out_max_o   = out_max_q;
  assign out_mean_o  = out_mean_q;
  assign out_p2p_o   = out_p2p_q;

  assign sts_o.func     = func_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  window_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= rmm_pkg::FillBits'(rmm_pkg::WinLen))
    else $error("window fill exceeds the window length");

  clear_restores_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply_clear |=> (count_q == '0 && p2p_q == '0))
    else $error("statistics clear did not reset count and peak-to-peak");

  count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply_sample && count_q == '1) |=> count_q == '1)
    else $error("sample count wrapped");

endmodule

// ===== rtl/rmm_ctrl.sv =====
// Controller state machine that sequences one word through the datapath.
module rmm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rmm_pkg::rmm_sts_t  sts_i,
  output rmm_pkg::rmm_cmd_t  cmd_o
);

  rmm_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmm_pkg::StIdle:   if (in_valid_i) state_d = rmm_pkg::StApply;
      rmm_pkg::StApply:  begin
        state_d = (sts_i.func == rmm_pkg::FuncClear) ? rmm_pkg::StResult : rmm_pkg::StDivide;
      end
      rmm_pkg::StDivide: if (sts_i.div_done) state_d = rmm_pkg::StCommit;
      rmm_pkg::StCommit: state_d = rmm_pkg::StResult;
      rmm_pkg::StResult: if (sts_i.out_free) state_d = rmm_pkg::StIdle;
      default:           state_d = rmm_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rmm_pkg::StIdle: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      rmm_pkg::StApply: begin
        cmd_o.apply_clear  = (sts_i.func == rmm_pkg::FuncClear);
        cmd_o.apply_sample = (sts_i.func == rmm_pkg::FuncSample);
      end
      rmm_pkg::StDivide: ;
      rmm_pkg::StCommit: cmd_o.mean_commit = 1'b1;
      rmm_pkg::StResult: cmd_o.push_result = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/running_min_max_mean_pk2pk_core.sv =====
// A sample word is answered after it has passed the 32-step radix-2 mean divider; a
// statistics-clear word skips the divider. A new word is accepted only once the result
// of the previous one has been pushed into the output register.
// The output register lets the next word be accepted while a result still waits downstream.
// Reset (rst_ni, asynchronous, active low) restores the register defaults and all statistics.
module running_min_max_mean_pk2pk_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rmm_in_if.sink                            in_i,
  rmm_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [rmm_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [rmm_pkg::CfgDataBits-1:0]   cfg_wdata_i
);

  // The controller sequences each word: capture, apply the min, max and window updates
  // (or the statistics clear), run the divider for the mean step, commit the mean and
  // hand the result to the output register once that register is free.
  rmm_pkg::rmm_cmd_t cmd;
  rmm_pkg::rmm_sts_t sts;
  logic              in_ready;

  rmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // The datapath holds the configuration, the statistics, the divider and the
  // output register; the mean is a Q1.31 accumulator whose upper half is reported.
  rmm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_func_i   (in_i.func),
    .in_sample_i (in_i.sample),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_min_o   (out_o.min_value),
    .out_max_o   (out_o.max_value),
    .out_mean_o  (out_o.mean_value),
    .out_p2p_o   (out_o.peak_to_peak)
  );

  // A result is only written into a free output register, so none is overwritten.
  push_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_result |-> sts.out_free)
    else $error("result pushed into an occupied output register");

  // An accepted word is applied in the very next cycle.
  accept_then_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> (cmd.apply_clear || cmd.apply_sample))
    else $error("accepted word was not applied");

  // The mean is committed right after the divider finishes.
  done_then_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.div_done |=> cmd.mean_commit)
    else $error("divider result was not committed");

endmodule

// ===== test/tb_running_min_max_mean_pk2pk_core.sv =====
// Self-checking testbench for the running min/max/mean and windowed peak-to-peak core.
module tb_running_min_max_mean_pk2pk_core;
  timeunit 1ns;
  timeprecision 1ps;

  // A stall or a gap lasts at most this many cycles.
  localparam int unsigned StallMax = 13;
  // The run is declared hung after this many cycles in which no word moves on either channel.
  // The slowest legitimate stretch is a sample word through the divider plus a full stall on
  // each side plus a register update, which is far below this figure.
  localparam int unsigned HangLimit = 3000;
  // Cycles allowed after the last result for a stray word to show up.
  localparam int unsigned SettleCycles = 40;
  // The fourth index of the configuration port maps to no register and must be ignored.
  localparam logic [rmm_pkg::CfgIdxBits-1:0] CfgSpareIdx = 2'd3;

  // One result word as the core presents it.
  typedef struct packed {
    rmm_pkg::sample_t min_value;
    rmm_pkg::sample_t max_value;
    rmm_pkg::sample_t mean_value;
    rmm_pkg::sample_t peak_to_peak;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [rmm_pkg::CfgIdxBits-1:0] cfg_idx;
  logic [rmm_pkg::CfgDataBits-1:0] cfg_wdata;

  rmm_in_if  in_ch ();
  rmm_out_if out_ch ();

  running_min_max_mean_pk2pk_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Predictor. Its registers and statistics mirror what the core should hold after every
  // accepted word; the words it computes wait in stats_due_q until the core answers.
  // ---------------------------------------------------------------------------------------
  rmm_pkg::sample_t limit_reg;
  rmm_pkg::sample_t min_seed_reg;
  rmm_pkg::sample_t mean_seed_reg;
  rmm_pkg::sample_t run_min;
  rmm_pkg::sample_t run_max;
  logic [31:0]      mean_acc;
  logic [31:0]      smp_count;
  logic [7:0]       win_fill;
  rmm_pkg::sample_t win_high;
  rmm_pkg::sample_t win_low;
  rmm_pkg::sample_t last_p2p;

  stats_t stats_due_q[$];
  stats_t head_stats;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold = 0;
  bit idle_on;

  // A statistics clear restores min, max, mean, peak-to-peak and the count, but leaves
  // the window alone.
  function automatic void clear_stats();
    run_max   = '0;
    run_min   = min_seed_reg;
    mean_acc  = {mean_seed_reg, 16'h0000};
    last_p2p  = '0;
    smp_count = '0;
  endfunction

  // The window restarts empty, with its low seeded from the current min_seed.
  function automatic void clear_window();
    win_fill = '0;
    win_high = '0;
    win_low  = min_seed_reg;
  endfunction

  function automatic void reset_model();
    limit_reg     = rmm_pkg::MaxLimitRst;
    min_seed_reg  = rmm_pkg::MinSeedRst;
    mean_seed_reg = rmm_pkg::MeanSeedRst;
    clear_stats();
    clear_window();
  endfunction

  // Advances the statistics by one word and returns the result the core should produce.
  function automatic stats_t step_stats(input logic func, input rmm_pkg::sample_t smp);
    longint diff;
    longint divisor;
    stats_t res;
    if (func == rmm_pkg::FuncClear) begin
      clear_stats();
    end else begin
      // Samples at or above the limit never raise the maximum.
      if (smp > run_max && smp < limit_reg) begin
        run_max = smp;
      end
      if (smp < run_min) begin
        run_min = smp;
      end
      // The count saturates instead of wrapping.
      if (smp_count != '1) begin
        smp_count = smp_count + 32'd1;
      end
      // The divisor is the already incremented count plus one; the quotient truncates
      // toward zero, so a falling mean moves down by the truncated magnitude.
      diff     = (longint'(smp) <<< rmm_pkg::MeanShift) - longint'(mean_acc);
      divisor  = longint'(smp_count) + 1;
      mean_acc = mean_acc + 32'(diff / divisor);
      if (win_fill < rmm_pkg::WinLen) begin
        if (smp > win_high) begin
          win_high = smp;
        end
        if (smp < win_low) begin
          win_low = smp;
        end
        win_fill = win_fill + 8'd1;
      end else begin
        // The word that finds the window full latches its span and is not stored.
        last_p2p = (win_high >= win_low) ? rmm_pkg::sample_t'(win_high - win_low) : '0;
        clear_window();
      end
    end
    res.min_value    = run_min;
    res.max_value    = run_max;
    res.mean_value   = mean_acc[31:16];
    res.peak_to_peak = last_p2p;
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers. All driving happens at the falling edge.
  // ---------------------------------------------------------------------------------------

  // Sends one word and books its expected result once the handshake completes. Valid is
  // lowered here only when a gap is inserted, so back-to-back words keep it high throughout.
  task automatic send_word(input logic func, input rmm_pkg::sample_t smp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, StallMax)) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.func   <= func;
    in_ch.sample <= smp;
    do @(posedge clk); while (!in_ch.ready);
    stats_due_q.push_back(step_stats(func, smp));
    @(negedge clk);
  endtask

  // Holds the sender off until every booked result has come back, then lets the core
  // settle. Register writes are only issued after this.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (stats_due_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rmm_pkg::CfgIdxBits-1:0] idx,
                           input logic [rmm_pkg::CfgDataBits-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    unique case (idx)
      rmm_pkg::CfgMaxLimit: limit_reg = val;
      rmm_pkg::CfgMinSeed:  min_seed_reg = val;
      rmm_pkg::CfgMeanSeed: mean_seed_reg = val;
      default: ;
    endcase
  endtask

  // Writes all three registers, plus random data to the unused index, which must not
  // disturb anything.
  task automatic set_config(input rmm_pkg::sample_t limit, input rmm_pkg::sample_t min_seed,
                            input rmm_pkg::sample_t mean_seed);
    drain_results();
    write_reg(rmm_pkg::CfgMaxLimit, limit);
    write_reg(CfgSpareIdx, rmm_pkg::CfgDataBits'($urandom));
    write_reg(rmm_pkg::CfgMinSeed, min_seed);
    write_reg(rmm_pkg::CfgMeanSeed, mean_seed);
  endtask

  // A value within span of center, clamped to the sample range.
  function automatic rmm_pkg::sample_t around(input rmm_pkg::sample_t center, input int span);
    int v;
    v = int'(center) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) begin
      v = 0;
    end else if (v > 65535) begin
      v = 65535;
    end
    return rmm_pkg::sample_t'(v);
  endfunction

  // Random samples lean toward the interesting spots: the min seed, the maximum limit and
  // both ends of the range, with a large share of fully random values.
  function automatic rmm_pkg::sample_t pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      return rmm_pkg::sample_t'($urandom);
    end else if (sel < 65) begin
      return around(min_seed_reg, 3000);
    end else if (sel < 85) begin
      return around(limit_reg, 8);
    end else if (sel < 93) begin
      return rmm_pkg::sample_t'($urandom_range(0, 15));
    end else begin
      return rmm_pkg::sample_t'(16'hFFFF - $urandom_range(0, 15));
    end
  endfunction

  // Statistics clears are kept rare so that the mean and count get long runs.
  task automatic send_random_word();
    if ($urandom_range(0, 99) < 4) begin
      send_word(rmm_pkg::FuncClear, rmm_pkg::sample_t'($urandom));
    end else begin
      send_word(rmm_pkg::FuncSample, pick_sample());
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Register defaults after reset: the ends of the range, both sides of the maximum limit,
  // the min seed itself, alternating bit patterns, and clears (one carrying a sample that
  // must be ignored, two in a row).
  task automatic test_defaults();
    send_word(rmm_pkg::FuncSample, 16'h8000);
    send_word(rmm_pkg::FuncSample, 16'h0000);
    send_word(rmm_pkg::FuncSample, 16'hFFFF);
    send_word(rmm_pkg::FuncSample, rmm_pkg::MaxLimitRst - 16'd1);
    send_word(rmm_pkg::FuncSample, rmm_pkg::MaxLimitRst);
    send_word(rmm_pkg::FuncSample, rmm_pkg::MinSeedRst);
    send_word(rmm_pkg::FuncSample, rmm_pkg::MinSeedRst + 16'd1);
    send_word(rmm_pkg::FuncClear, 16'hFFFF);
    send_word(rmm_pkg::FuncSample, 16'h5555);
    send_word(rmm_pkg::FuncSample, 16'hAAAA);
    send_word(rmm_pkg::FuncClear, 16'h0000);
    send_word(rmm_pkg::FuncClear, 16'h1234);
  endtask

  // Register extremes. A zero limit blocks every maximum update; a full-scale min seed is
  // beaten by every sample below full scale. Then the opposite corner, where only full
  // scale is rejected and a zero seed is never beaten. Seeds take effect on the clears.
  task automatic test_register_extremes();
    set_config(16'h0000, 16'hFFFF, 16'h0000);
    send_word(rmm_pkg::FuncSample, 16'hFFFF);
    send_word(rmm_pkg::FuncClear, 16'h0000);
    send_word(rmm_pkg::FuncSample, 16'h0000);
    send_word(rmm_pkg::FuncSample, 16'h0001);
    send_word(rmm_pkg::FuncSample, 16'd100);
    set_config(16'hFFFF, 16'h0000, 16'hFFFF);
    send_word(rmm_pkg::FuncClear, 16'hFFFF);
    send_word(rmm_pkg::FuncSample, 16'hFFFE);
    send_word(rmm_pkg::FuncSample, 16'hFFFF);
    send_word(rmm_pkg::FuncSample, 16'd7);
  endtask

  // Long random phases, each under its own register setting, so that windows complete and
  // latch a peak-to-peak under each. Idling is switched on and off in stretches, and
  // halfway through each phase the sender waits for every result.
  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        1:       set_config(16'hFFFF, 16'h0000, rmm_pkg::sample_t'($urandom));
        2:       set_config(rmm_pkg::sample_t'($urandom), 16'hFFFF, 16'h0000);
        default: set_config(rmm_pkg::sample_t'($urandom), rmm_pkg::sample_t'($urandom),
                            rmm_pkg::sample_t'($urandom));
      endcase
      for (int n = 0; n < 320; n++) begin
        if (n % 40 == 0) begin
          idle_on = ($urandom_range(0, 3) != 0);
        end
        if (n == 160) begin
          drain_results();
        end
        send_random_word();
      end
    end
  endtask

  // Closing stream with the sink always ready and no gaps from the sender.
  task automatic test_steady_stream();
    set_config(rmm_pkg::MaxLimitRst, rmm_pkg::MinSeedRst, rmm_pkg::MeanSeedRst);
    idle_on = 1'b0;
    for (int n = 0; n < 150; n++) begin
      send_random_word();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side: random backpressure on ready, and the scoreboard check of every word.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold    <= sink_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_hold    <= $urandom_range(0, StallMax - 1);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input rmm_pkg::sample_t got,
                                 input rmm_pkg::sample_t want);
    $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (stats_due_q.size() == 0) begin
        report_mismatch("result word with none pending, min", out_ch.min_value, '0);
      end else begin
        head_stats = stats_due_q.pop_front();
        if (out_ch.min_value !== head_stats.min_value) begin
          report_mismatch("min_value", out_ch.min_value, head_stats.min_value);
        end
        if (out_ch.max_value !== head_stats.max_value) begin
          report_mismatch("max_value", out_ch.max_value, head_stats.max_value);
        end
        if (out_ch.mean_value !== head_stats.mean_value) begin
          report_mismatch("mean_value", out_ch.mean_value, head_stats.mean_value);
        end
        if (out_ch.peak_to_peak !== head_stats.peak_to_peak) begin
          report_mismatch("peak_to_peak", out_ch.peak_to_peak, head_stats.peak_to_peak);
        end
      end
    end
  end

  // Hang detection: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= HangLimit) begin
      $display("tb_running_min_max_mean_pk2pk_core: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = rmm_pkg::CfgMaxLimit;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = rmm_pkg::FuncSample;
    in_ch.sample = '0;
    idle_on      = 1'b1;
    reset_model();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_defaults();
    test_register_extremes();
    test_random_phases();
    test_steady_stream();

    // Everything is sent; wait for the last results and give a stray word time to appear.
    in_ch.valid <= 1'b0;
    while (stats_due_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_running_min_max_mean_pk2pk_core: done, clean");
    end else begin
      $display("tb_running_min_max_mean_pk2pk_core: done, errors");
    end
    $finish;
  end

endmodule
